// ===== design/cjeb_pkg.sv =====
// Package for the calorimeter jet energy breakdown unit.
// Holds the sequencer states, region codes, register indexes and divider status type.
// No dependencies.
`default_nettype none

package cjeb_pkg;

  localparam int unsigned RingBits = 6;
  localparam int unsigned EtaBits  = 7;
  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_BARREL_LAST  = 2'd0,
    CFG_ENDCAP_LAST  = 2'd1,
    CFG_FORWARD_LAST = 2'd2
  } cjeb_cfg_idx_e;

  typedef enum logic [1:0] {
    REGION_BARREL  = 2'd0,
    REGION_ENDCAP  = 2'd1,
    REGION_FORWARD = 2'd2,
    REGION_NONE    = 2'd3
  } cjeb_region_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HAD_START,
    ST_HAD_WAIT,
    ST_EM_START,
    ST_EM_WAIT,
    ST_OUT
  } cjeb_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cjeb_div_status_t;

endpackage

`default_nettype wire

// ===== design/calo_jet_energy_breakdown_unit.sv =====
// Calorimeter jet energy breakdown unit: top level with sequencer and result register.
// Towers without the last flag are accepted back to back while idle. A last tower is
// followed by two divisions on the shared divider, hadronic then EM fraction, and a
// load into the result register once the last result is taken, then input reopens.
// Reset restores the ring limits to 16, 29 and 41 and clears all per-jet sums.
// Depends on cjeb_pkg, cjeb_accum and cjeb_divider.
`default_nettype none

module calo_jet_energy_breakdown_unit import cjeb_pkg::*; #(
  parameter int unsigned ENERGY_BITS   = 16,
  parameter int unsigned SUM_BITS      = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_wr_en_i,
  input  wire logic [CfgIdxBits-1:0]     cfg_idx_i,
  input  wire logic [RingBits-1:0]       cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [EtaBits-1:0] eta_ring_i,
  input  wire logic [ENERGY_BITS-1:0]    em_energy_i,
  input  wire logic [ENERGY_BITS-1:0]    had_energy_i,
  input  wire logic [ENERGY_BITS-1:0]    outer_energy_i,
  input  wire logic                      tower_valid_i,
  input  wire logic                      last_tower_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [SUM_BITS-1:0]            outer_sum_o,
  output logic [SUM_BITS-1:0]            barrel_had_sum_o,
  output logic [SUM_BITS-1:0]            endcap_had_sum_o,
  output logic [SUM_BITS-1:0]            forward_had_sum_o,
  output logic [SUM_BITS-1:0]            forward_em_sum_o,
  output logic [SUM_BITS-1:0]            barrel_em_sum_o,
  output logic [SUM_BITS-1:0]            endcap_em_sum_o,
  output logic [FRACTION_BITS-1:0]       had_fraction_o,
  output logic [FRACTION_BITS-1:0]       em_fraction_o,
  output logic [ENERGY_BITS-1:0]         max_em_tower_o,
  output logic [ENERGY_BITS-1:0]         max_had_tower_o
);

  localparam int unsigned OperBits = SUM_BITS + 1;

  cjeb_state_e            state_q, state_d;
  logic [RingBits-1:0]    barrel_last_q, endcap_last_q, forward_last_q;
  logic                   in_fire, load, div_start;
  logic [SUM_BITS-1:0]    em_total, had_total, outer_sum;
  logic [SUM_BITS-1:0]    region_had [3];
  logic [SUM_BITS-1:0]    region_em [3];
  logic [ENERGY_BITS-1:0] max_em, max_had;
  logic [OperBits-1:0]    div_num, div_den;
  cjeb_div_status_t       div_st;
  logic [FRACTION_BITS-1:0] quotient, had_frac_q;
  logic                   out_valid_q;

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      barrel_last_q  <= RingBits'(16);
      endcap_last_q  <= RingBits'(29);
      forward_last_q <= RingBits'(41);
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        CFG_BARREL_LAST:  barrel_last_q  <= cfg_wdata_i;
        CFG_ENDCAP_LAST:  endcap_last_q  <= cfg_wdata_i;
        CFG_FORWARD_LAST: forward_last_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cjeb_accum #(
    .ENERGY_BITS(ENERGY_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_accum (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .clear_i            (load),
    .add_i              (in_fire && tower_valid_i),
    .eta_ring_i         (eta_ring_i),
    .em_energy_i        (em_energy_i),
    .had_energy_i       (had_energy_i),
    .outer_energy_i     (outer_energy_i),
    .barrel_last_ring_i (barrel_last_q),
    .endcap_last_ring_i (endcap_last_q),
    .forward_last_ring_i(forward_last_q),
    .em_total_o         (em_total),
    .had_total_o        (had_total),
    .outer_sum_o        (outer_sum),
    .region_had_o       (region_had),
    .region_em_o        (region_em),
    .max_em_o           (max_em),
    .max_had_o          (max_had)
  );

  assign div_den = OperBits'(had_total) + OperBits'(em_total);
  assign div_num = (state_q == ST_HAD_START) ? OperBits'(had_total) : OperBits'(em_total);

  cjeb_divider #(
    .OPER_BITS(OperBits),
    .FRAC_BITS(FRACTION_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .num_i     (div_num),
    .den_i     (div_den),
    .status_o  (div_st),
    .quotient_o(quotient)
  );

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && last_tower_i) begin
          state_d = ST_HAD_START;
        end
      end
      ST_HAD_START: begin
        div_start = 1'b1;
        state_d   = ST_HAD_WAIT;
      end
      ST_HAD_WAIT: begin
        if (div_st.done) begin
          state_d = ST_EM_START;
        end
      end
      ST_EM_START: begin
        div_start = 1'b1;
        state_d   = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (div_st.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HAD_WAIT && div_st.done) begin
      had_frac_q <= quotient;
    end
    if (load) begin
      outer_sum_o       <= outer_sum;
      barrel_had_sum_o  <= region_had[REGION_BARREL];
      endcap_had_sum_o  <= region_had[REGION_ENDCAP];
      forward_had_sum_o <= region_had[REGION_FORWARD];
      forward_em_sum_o  <= region_em[REGION_FORWARD];
      barrel_em_sum_o   <= region_em[REGION_BARREL];
      endcap_em_sum_o   <= region_em[REGION_ENDCAP];
      had_fraction_o    <= had_frac_q;
      em_fraction_o     <= quotient;
      max_em_tower_o    <= max_em;
      max_had_tower_o   <= max_had;
    end
  end

  assign out_valid_o = out_valid_q;

  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_tower_i |=> !in_ready_o)
    else $error("input still open after last tower transfer");

  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_HAD_WAIT || state_q == ST_EM_WAIT))
    else $error("divider finished outside a wait state");

  a_clear_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (em_total == '0 && had_total == '0 && max_em == '0 && max_had == '0))
    else $error("per-jet state not cleared after result load");

  a_fractions_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((FRACTION_BITS+1)'(had_fraction_o) + (FRACTION_BITS+1)'(em_fraction_o)
                     <= {1'b1, {FRACTION_BITS{1'b0}}}))
    else $error("fractions exceed one");

endmodule

`default_nettype wire

// ===== design/cjeb_accum.sv =====
// Per-jet accumulators: region classification, saturating sums and tower maxima.
// Depends on cjeb_pkg.
`default_nettype none

module cjeb_accum import cjeb_pkg::*; #(
  parameter int unsigned ENERGY_BITS = 16,
  parameter int unsigned SUM_BITS    = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       add_i,
  input  wire logic signed [EtaBits-1:0]  eta_ring_i,
  input  wire logic [ENERGY_BITS-1:0]     em_energy_i,
  input  wire logic [ENERGY_BITS-1:0]     had_energy_i,
  input  wire logic [ENERGY_BITS-1:0]     outer_energy_i,
  input  wire logic [RingBits-1:0]        barrel_last_ring_i,
  input  wire logic [RingBits-1:0]        endcap_last_ring_i,
  input  wire logic [RingBits-1:0]        forward_last_ring_i,
  output logic [SUM_BITS-1:0]             em_total_o,
  output logic [SUM_BITS-1:0]             had_total_o,
  output logic [SUM_BITS-1:0]             outer_sum_o,
  output logic [SUM_BITS-1:0]             region_had_o [3],
  output logic [SUM_BITS-1:0]             region_em_o [3],
  output logic [ENERGY_BITS-1:0]          max_em_o,
  output logic [ENERGY_BITS-1:0]          max_had_o
);

  localparam int unsigned AddBits = ((SUM_BITS > ENERGY_BITS) ? SUM_BITS : ENERGY_BITS) + 1;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] acc,
                                                  input logic [ENERGY_BITS-1:0] val);
    logic [AddBits-1:0] s;
    s = AddBits'(acc) + AddBits'(val);
    sat_add = (|s[AddBits-1:SUM_BITS]) ? '1 : s[SUM_BITS-1:0];
  endfunction

  logic [EtaBits-1:0]     eta_raw;
  logic [EtaBits-1:0]     abs_eta;
  cjeb_region_e           region;
  logic [SUM_BITS-1:0]    em_total_q, had_total_q, outer_q;
  logic [SUM_BITS-1:0]    region_had_q [3];
  logic [SUM_BITS-1:0]    region_em_q [3];
  logic [ENERGY_BITS-1:0] max_em_q, max_had_q;

  always_comb begin
    eta_raw = eta_ring_i;
    abs_eta = eta_raw[EtaBits-1] ? (EtaBits'(0) - eta_raw) : eta_raw;
    if (abs_eta <= {1'b0, barrel_last_ring_i}) begin
      region = REGION_BARREL;
    end else if (abs_eta <= {1'b0, endcap_last_ring_i}) begin
      region = REGION_ENDCAP;
    end else if (abs_eta <= {1'b0, forward_last_ring_i}) begin
      region = REGION_FORWARD;
    end else begin
      region = REGION_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_total_q  <= '0;
      had_total_q <= '0;
      outer_q     <= '0;
      max_em_q    <= '0;
      max_had_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        region_had_q[i] <= '0;
        region_em_q[i]  <= '0;
      end
    end else if (clear_i) begin
      em_total_q  <= '0;
      had_total_q <= '0;
      outer_q     <= '0;
      max_em_q    <= '0;
      max_had_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        region_had_q[i] <= '0;
        region_em_q[i]  <= '0;
      end
    end else if (add_i) begin
      em_total_q  <= sat_add(em_total_q, em_energy_i);
      had_total_q <= sat_add(had_total_q, had_energy_i);
      outer_q     <= sat_add(outer_q, outer_energy_i);
      if (em_energy_i > max_em_q) begin
        max_em_q <= em_energy_i;
      end
      if (had_energy_i > max_had_q) begin
        max_had_q <= had_energy_i;
      end
      for (int i = 0; i < 3; i++) begin
        if (region == cjeb_region_e'(2'(i))) begin
          region_had_q[i] <= sat_add(region_had_q[i], had_energy_i);
          region_em_q[i]  <= sat_add(region_em_q[i], em_energy_i);
        end
      end
    end
  end

  assign em_total_o  = em_total_q;
  assign had_total_o = had_total_q;
  assign outer_sum_o = outer_q;
  assign max_em_o    = max_em_q;
  assign max_had_o   = max_had_q;
  assign region_had_o = region_had_q;
  assign region_em_o  = region_em_q;

endmodule

`default_nettype wire

// ===== design/cjeb_divider.sv =====
// Shared restoring divider: one quotient bit per cycle, num * 2^FRAC_BITS / den.
// Zero divisor gives zero, num >= den saturates. Depends on cjeb_pkg.
`default_nettype none

module cjeb_divider import cjeb_pkg::*; #(
  parameter int unsigned OPER_BITS = 25,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [OPER_BITS-1:0] num_i,
  input  wire logic [OPER_BITS-1:0] den_i,
  output cjeb_div_status_t          status_o,
  output logic [FRAC_BITS-1:0]      quotient_o
);

  localparam int unsigned CntBits = $clog2(FRAC_BITS);
  localparam logic [CntBits-1:0] LastStep = CntBits'(FRAC_BITS - 1);

  logic                 busy_q, done_q, zero_q, full_q;
  logic [CntBits-1:0]   cnt_q;
  logic [OPER_BITS-1:0] rem_q, den_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic [OPER_BITS:0]   rem_shift;
  logic                 take;

  assign rem_shift = {rem_q, 1'b0};
  assign take      = rem_shift >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quo_q  <= '0;
      zero_q <= (den_i == '0);
      full_q <= (num_i >= den_i);
    end else if (busy_q) begin
      rem_q <= take ? OPER_BITS'(rem_shift - {1'b0, den_q}) : rem_shift[OPER_BITS-1:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], take};
    end
  end

  assign quotient_o    = zero_q ? '0 : (full_q ? '1 : quo_q);
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

`default_nettype wire
